### hw/rtl/tcse_pkg.sv
// Package for the TCP connection state engine: table size, state codes,
// flag codes and the command and status structs between control and datapath.
`timescale 1ns / 1ps
package tcse_pkg;
	localparam int MaxConnections = 8;
	localparam int IdxW = (MaxConnections > 1) ? $clog2(MaxConnections) : 1;
	localparam int CntW = $clog2(MaxConnections + 1);
	localparam logic [31:0] InitWindow = 32'd1024;

	localparam logic [3:0] S_CLOSED = 4'd0;
	localparam logic [3:0] S_LISTEN = 4'd1;
	localparam logic [3:0] S_SYN_SENT = 4'd2;
	localparam logic [3:0] S_SYN_RCVD = 4'd3;
	localparam logic [3:0] S_ESTAB = 4'd4;
	localparam logic [3:0] S_FIN_WAIT_1 = 4'd5;
	localparam logic [3:0] S_FIN_WAIT_2 = 4'd6;
	localparam logic [3:0] S_CLOSE_WAIT = 4'd7;
	localparam logic [3:0] S_CLOSING = 4'd8;
	localparam logic [3:0] S_LAST_ACK = 4'd9;
	localparam logic [3:0] S_TIMED_WAIT = 4'd10;

	localparam logic [4:0] F_RST = 5'h04;
	localparam logic [4:0] F_ACK = 5'h10;
	localparam logic [4:0] F_SYNACK = 5'h12;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_CKSUM = 2'd1;
	localparam logic [1:0] ST_NOCONN = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	typedef struct packed {
		logic load;
		logic scan_start;
		logic [CntW-1:0] scan_idx;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic exact_hit;
		logic listen_hit;
		logic closed_hit;
	} stat_t;
endpackage

### hw/rtl/tcse_ctrl.sv
// Controller for the TCP connection state engine: sequences one scan over
// all slots and a commit step. Depends on tcse_pkg.
`timescale 1ns / 1ps
module tcse_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	output tcse_pkg::cmd_t cmd
);
	typedef enum logic [1:0] {IDLE, SCAN, COMMIT} state_t;
	state_t state_q;
	logic [tcse_pkg::CntW-1:0] idx_q;

	always_comb begin
		cmd.load = (state_q == IDLE) && start;
		cmd.scan_start = (state_q == SCAN) && (idx_q == '0);
		cmd.scan_idx = idx_q;
		cmd.commit = (state_q == COMMIT);
		busy = (state_q != IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			idx_q <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					idx_q <= '0;
					if (start) state_q <= SCAN;
				end
				SCAN: begin
					if (idx_q == tcse_pkg::CntW'(tcse_pkg::MaxConnections - 1))
						state_q <= COMMIT;
					idx_q <= idx_q + 1'b1;
				end
				COMMIT: state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

### hw/rtl/tcse_dp.sv
// Datapath for the TCP connection state engine: slot table, scan results and
// the state step with result registers. Depends on tcse_pkg.
`timescale 1ns / 1ps
module tcse_dp (
	input logic clk,
	input logic arst_n,
	input tcse_pkg::cmd_t cmd,
	input logic action,
	input logic checksum_ok,
	input logic [31:0] remote_addr,
	input logic [15:0] remote_port,
	input logic [15:0] local_port,
	input logic [31:0] seq_num,
	input logic [31:0] ack_num,
	input logic [15:0] window,
	input logic [7:0] tcp_flags,
	output logic done,
	output logic [1:0] status,
	output logic [2:0] slot,
	output logic [4:0] send_flags,
	output logic [31:0] reply_seq,
	output logic [31:0] reply_ack,
	output logic [3:0] new_state,
	output logic accepted
);
	localparam int N = tcse_pkg::MaxConnections;
	localparam int W = tcse_pkg::IdxW;

	logic [3:0] cst_q [N];
	logic [15:0] oport_q [N];
	logic [15:0] pport_q [N];
	logic [31:0] paddr_q [N];
	logic [31:0] oseq_q [N];
	logic [31:0] ats_q [N];
	logic [31:0] slim_q [N];
	logic [2:0] par_q [N];
	logic [N-1:0] acct_q;

	logic act_q, ck_q;
	logic [31:0] raddr_q, seq_q, ackn_q;
	logic [15:0] rport_q, lport_q, win_q;
	logic [7:0] fl_q;
	logic ex_v_q, li_v_q, cl_v_q;
	logic [W-1:0] ex_i_q, li_i_q, cl_i_q;

	logic [W-1:0] si;
	assign si = cmd.scan_idx[W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			ck_q <= checksum_ok;
			raddr_q <= remote_addr;
			rport_q <= remote_port;
			lport_q <= local_port;
			seq_q <= seq_num;
			ackn_q <= ack_num;
			win_q <= window;
			fl_q <= tcp_flags;
		end
	end

	logic e_m, l_m, c_m;
	assign e_m = oport_q[si] == lport_q && pport_q[si] == rport_q && paddr_q[si] == raddr_q;
	assign l_m = oport_q[si] == lport_q && cst_q[si] == tcse_pkg::S_LISTEN;
	assign c_m = cst_q[si] == tcse_pkg::S_CLOSED;

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			ex_v_q <= e_m; ex_i_q <= si;
			li_v_q <= l_m; li_i_q <= si;
			cl_v_q <= c_m; cl_i_q <= si;
		end else if (!cmd.load && !cmd.commit && !done) begin
			if (!ex_v_q && e_m) begin ex_v_q <= 1'b1; ex_i_q <= si; end
			if (!li_v_q && l_m) begin li_v_q <= 1'b1; li_i_q <= si; end
			if (!cl_v_q && c_m) begin cl_v_q <= 1'b1; cl_i_q <= si; end
		end
	end

	// Step logic evaluated in the commit cycle.
	logic fin, syn, ack;
	assign fin = fl_q[0];
	assign syn = fl_q[1];
	assign ack = fl_q[4];

	logic [1:0] r_st;
	logic [4:0] r_fl;
	logic [31:0] r_seq, r_ack;
	logic r_acc, r_has;
	logic [W-1:0] s, p, m;
	logic [3:0] st, ns;
	logic [31:0] nats;
	logic wr_sel, wr_child, wr_listen, wr_acc, fixed;

	always_comb begin
		r_st = tcse_pkg::ST_OK;
		r_fl = '0;
		r_seq = '0;
		r_ack = '0;
		r_acc = 1'b0;
		r_has = 1'b0;
		s = '0;
		st = '0;
		ns = '0;
		nats = '0;
		wr_sel = 1'b0;
		wr_child = 1'b0;
		wr_listen = 1'b0;
		wr_acc = 1'b0;
		fixed = 1'b0;
		m = ex_v_q ? ex_i_q : li_i_q;
		p = par_q[m][W-1:0];
		if (act_q) begin
			if (!cl_v_q) begin
				r_st = tcse_pkg::ST_FULL;
				r_has = 1'b1;
			end else begin
				s = cl_i_q;
				wr_listen = 1'b1;
				r_has = 1'b1;
				ns = tcse_pkg::S_LISTEN;
			end
		end else if (!ck_q) begin
			r_st = tcse_pkg::ST_CKSUM;
		end else if (!ex_v_q && !li_v_q) begin
			r_st = tcse_pkg::ST_NOCONN;
		end else begin
			s = m;
			st = cst_q[s];
			ns = st;
			nats = ats_q[s];
			r_has = 1'b1;
			case (st)
				tcse_pkg::S_CLOSED: r_fl = tcse_pkg::F_RST;
				tcse_pkg::S_LISTEN: begin
					if (syn) begin
						if (!cl_v_q) r_st = tcse_pkg::ST_FULL;
						else begin
							wr_child = 1'b1;
							s = cl_i_q;
							ns = tcse_pkg::S_SYN_RCVD;
							r_fl = tcse_pkg::F_SYNACK;
							r_seq = 32'd1;
							r_ack = seq_q + 32'd1;
							fixed = 1'b1;
						end
					end
				end
				tcse_pkg::S_SYN_SENT: begin
					if (syn) begin
						wr_sel = 1'b1;
						nats = seq_q + 32'd1;
						if (ack) begin
							ns = fin ? tcse_pkg::S_CLOSE_WAIT : tcse_pkg::S_ESTAB;
							if (fin) nats = seq_q + 32'd2;
							r_fl = tcse_pkg::F_ACK;
						end else begin
							ns = tcse_pkg::S_SYN_RCVD;
							r_fl = tcse_pkg::F_SYNACK;
						end
					end
				end
				tcse_pkg::S_SYN_RCVD: begin
					if (ack) begin
						wr_sel = 1'b1;
						ns = tcse_pkg::S_ESTAB;
						if (fin) begin
							ns = tcse_pkg::S_CLOSE_WAIT;
							nats = ats_q[s] + 32'd1;
							r_fl = tcse_pkg::F_ACK;
						end
						if ((32'(par_q[s]) < 32'(N)) && !acct_q[p]) begin
							wr_acc = 1'b1;
							r_acc = 1'b1;
						end
					end
				end
				tcse_pkg::S_ESTAB, tcse_pkg::S_FIN_WAIT_2: begin
					if (fin) begin
						wr_sel = 1'b1;
						ns = (st == tcse_pkg::S_ESTAB) ? tcse_pkg::S_CLOSE_WAIT
							: tcse_pkg::S_TIMED_WAIT;
						nats = ats_q[s] + 32'd1;
						r_fl = tcse_pkg::F_ACK;
					end
				end
				tcse_pkg::S_FIN_WAIT_1: begin
					wr_sel = fin || ack;
					if (fin) begin
						ns = ack ? tcse_pkg::S_TIMED_WAIT : tcse_pkg::S_CLOSING;
						nats = ats_q[s] + 32'd1;
						r_fl = tcse_pkg::F_ACK;
					end else if (ack) ns = tcse_pkg::S_FIN_WAIT_2;
				end
				tcse_pkg::S_LAST_ACK: begin
					if (ack) begin
						wr_sel = 1'b1;
						ns = tcse_pkg::S_CLOSED;
					end
				end
				default: ;
			endcase
			if (r_fl != '0 && r_fl != tcse_pkg::F_RST && !fixed) begin
				r_seq = oseq_q[s];
				r_ack = nats;
			end
		end
	end

	logic slim_upd;
	assign slim_upd = r_st == tcse_pkg::ST_OK && !act_q && (ns == tcse_pkg::S_ESTAB
		|| ns == tcse_pkg::S_FIN_WAIT_1 || ns == tcse_pkg::S_FIN_WAIT_2
		|| ns == tcse_pkg::S_CLOSE_WAIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				cst_q[i] <= tcse_pkg::S_CLOSED;
				oport_q[i] <= '0;
				pport_q[i] <= '0;
				paddr_q[i] <= '0;
				oseq_q[i] <= '0;
				ats_q[i] <= '0;
				slim_q[i] <= '0;
				par_q[i] <= '0;
			end
			acct_q <= '0;
			done <= 1'b0;
		end else begin
			done <= cmd.commit;
			if (cmd.commit) begin
				if (wr_listen || wr_child) begin
					cst_q[s] <= ns;
					oport_q[s] <= lport_q;
					pport_q[s] <= wr_child ? rport_q : 16'd0;
					paddr_q[s] <= wr_child ? raddr_q : 32'd0;
					oseq_q[s] <= wr_child ? 32'd2 : 32'd0;
					ats_q[s] <= wr_child ? seq_q + 32'd1 : 32'd0;
					slim_q[s] <= wr_child ? 32'd1 + tcse_pkg::InitWindow : 32'd0;
					par_q[s] <= wr_child ? 3'(m) : 3'd0;
					acct_q[s] <= 1'b0;
				end
				if (wr_sel) begin
					cst_q[s] <= ns;
					ats_q[s] <= nats;
				end
				if (slim_upd) slim_q[s] <= ackn_q + {16'd0, win_q};
				if (wr_acc) acct_q[p] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status <= r_st;
			slot <= r_has ? 3'(s) : 3'd0;
			send_flags <= r_fl;
			reply_seq <= (r_fl != '0) ? r_seq : 32'd0;
			reply_ack <= (r_fl != '0) ? r_ack : 32'd0;
			new_state <= r_has ? ns : 4'd0;
			accepted <= r_acc;
		end
	end
endmodule

### hw/rtl/tcp_connection_state_engine.sv
// Top level of the TCP connection state engine: joins controller and datapath.
// Depends on tcse_pkg, tcse_ctrl and tcse_dp.
//
//  channel   handshake        payload
//  item in   start / busy     action .. tcp_flags
//  result    done (strobe)    status .. accepted
//
// An item is scanned slot by slot through the table compare logic in the SCAN
// state, then passes the COMMIT state, then done pulses.
// busy stays high from the transfer until the result appears.
// Reset clears every slot to CLOSED with zero fields. The receiver cannot stall.
`timescale 1ns / 1ps
module tcp_connection_state_engine (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic action,
	input logic checksum_ok,
	input logic [31:0] remote_addr,
	input logic [15:0] remote_port,
	input logic [15:0] local_port,
	input logic [31:0] seq_num,
	input logic [31:0] ack_num,
	input logic [15:0] window,
	input logic [7:0] tcp_flags,
	output logic done,
	output logic [1:0] status,
	output logic [2:0] slot,
	output logic [4:0] send_flags,
	output logic [31:0] reply_seq,
	output logic [31:0] reply_ack,
	output logic [3:0] new_state,
	output logic accepted
);
	tcse_pkg::cmd_t cmd;
	logic busy_c;

	tcse_ctrl u_ctrl (.clk(clk), .arst_n(arst_n), .start(start), .busy(busy_c), .cmd(cmd));
	assign busy = busy_c;

	tcse_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.action(action), .checksum_ok(checksum_ok), .remote_addr(remote_addr),
		.remote_port(remote_port), .local_port(local_port), .seq_num(seq_num),
		.ack_num(ack_num), .window(window), .tcp_flags(tcp_flags),
		.done(done), .status(status), .slot(slot), .send_flags(send_flags),
		.reply_seq(reply_seq), .reply_ack(reply_ack), .new_state(new_state),
		.accepted(accepted)
	);
endmodule
